// ----- rtl/soc_pkg.sv -----
`timescale 1ns / 1ps

package soc_pkg;

  // Pattern capacity in words.
  localparam int PATTERN_MAX = 128;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               match_here;
    logic               final_res;
    logic               pattern_overflow;
  } result_t;

endpackage

// ----- rtl/subarray_occurrence_counter_top.sv -----
`timescale 1ns / 1ps

// Overlapping pattern occurrence counter.
//
// Input channel (item_valid / item_stall / item_data): each transfer carries a
// command. A clear command empties the pattern and clears the count, the
// progress bits and the overflow flag. An append command adds one word to the
// pattern, or sets the overflow flag when the store is full. A text command
// feeds one text word and produces exactly one result; the other commands
// produce none.
// Result channel (res_valid / res_stall / res_data): the running count, whether
// an occurrence ends at this word, an echo of the last flag and the overflow
// flag. After a result with final_res set, the count and progress restart.
// Inputs pass through the input register, results through the result register.
// Throughput is one item per cycle while not stalled: each item is compared
// against every stored pattern word in parallel, one comparator per pattern
// position. When the receiver stalls, the result register holds, and a
// pending text item waits in the input register, which raises item_stall;
// commands that produce no result still go through. Synchronous reset empties
// both registers, the pattern length, the count and the progress bits.
module subarray_occurrence_counter_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  soc_pkg::item_t   item_data,
  output logic            res_valid,
  input  logic            res_stall,
  output soc_pkg::result_t res_data
);
  import soc_pkg::*;

  // Input register.
  logic  in_vld;
  item_t in_q;

  // Pattern state. The store has no reset; only entries below the length
  // are ever compared, which valid_mask guarantees.
  logic [31:0]            pat_store [PATTERN_MAX];
  logic [LEN_W-1:0]       pat_len;
  logic [PATTERN_MAX-1:0] valid_mask;   // bit p set when p < pat_len
  logic [PATTERN_MAX-1:0] last_mask;    // one-hot at pat_len - 1, or zero
  logic [PATTERN_MAX-1:0] progress;
  logic [PATTERN_MAX-1:0] progress_next;
  logic [COUNT_W-1:0]     occ_count;
  logic [COUNT_W-1:0]     occ_count_next;
  logic                   overflow_seen;

  logic       advance;
  logic       is_text;
  logic       here;
  logic       pat_full;
  logic [IDX_W-1:0] wr_idx;

  assign is_text  = (in_q.command == CMD_TEXT);
  // The input register moves on unless it holds a text item and the result
  // register is still occupied by a result the receiver has not taken.
  assign advance  = in_vld && (!is_text || !res_valid || !res_stall);
  assign item_stall = in_vld && !advance;

  assign pat_full = (pat_len == LEN_W'(PATTERN_MAX));
  assign wr_idx   = pat_len[IDX_W-1:0];

  // Each progress bit p becomes set when the previous position was matched
  // (position zero always starts fresh) and pattern word p equals the text word.
  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      progress_next[p] = valid_mask[p] &&
                         ((p == 0) ? 1'b1 : progress[(p == 0) ? 0 : p - 1]) &&
                         (pat_store[p] == in_q.value);
    end
  end

  assign here = |(progress_next & last_mask);
  assign occ_count_next = (here && (occ_count != COUNT_MAX)) ? occ_count + 1'b1
                                                             : occ_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.command == CMD_APPEND && !pat_full) begin
      pat_store[wr_idx] <= in_q.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len       <= '0;
      valid_mask    <= '0;
      last_mask     <= '0;
      progress      <= '0;
      occ_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      case (in_q.command)
        CMD_CLEAR: begin
          pat_len       <= '0;
          valid_mask    <= '0;
          last_mask     <= '0;
          progress      <= '0;
          occ_count     <= '0;
          overflow_seen <= 1'b0;
        end
        CMD_APPEND: begin
          if (pat_full) begin
            overflow_seen <= 1'b1;
          end else begin
            pat_len            <= pat_len + 1'b1;
            valid_mask[wr_idx] <= 1'b1;
            last_mask          <= {{(PATTERN_MAX-1){1'b0}}, 1'b1} << wr_idx;
            progress[wr_idx]   <= 1'b0;
          end
        end
        CMD_TEXT: begin
          if (in_q.last) begin
            progress  <= '0;
            occ_count <= '0;
          end else begin
            progress  <= progress_next;
            occ_count <= occ_count_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && is_text) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_text) begin
      res_data.match_count      <= occ_count_next;
      res_data.match_here       <= here;
      res_data.final_res        <= in_q.last;
      res_data.pattern_overflow <= overflow_seen;
    end
  end

endmodule

// ----- rtl/soc_checker.sv -----
`timescale 1ns / 1ps

module soc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             res_valid,
  input logic             res_stall,
  input soc_pkg::result_t res_data
);
  import soc_pkg::*;

  logic after_final;

  // Set once a final result has been transferred, cleared by the next transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_final <= 1'b0;
    end else if (res_valid && !res_stall) begin
      after_final <= res_data.final_res;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed or dropped");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !item_stall)
    else $error("input stalled while the result register is empty");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.match_here |-> res_data.match_count != '0)
    else $error("occurrence reported with a zero count");

  a_count_restarts: assert property (@(posedge clk) disable iff (rst)
    res_valid && after_final |->
      res_data.match_count == COUNT_W'(res_data.match_here))
    else $error("count did not restart after the end of a text");

endmodule

bind subarray_occurrence_counter_top soc_checker u_soc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_stall (item_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_data   (res_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the overlapping pattern occurrence counter.
// A behavioral copy of the counter runs next to the block. It is updated on
// every input transfer, and each text word queues the report that the block
// has to give for it. A monitor takes every result transfer and compares it,
// field by field, with the oldest queued report. Stimulus comes from a few
// named tests: directed corner cases first, then a full pattern store and
// random texts under three idling mixes.
module testbench;
  import soc_pkg::*;

  // The block has no code 3. It must ignore such a transfer.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item_data = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res_data;

  // Idling percentages for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count = 0;
  int cycle_count = 0;

  // Behavioral copy of the counter state.
  logic [31:0]            pattern_words [PATTERN_MAX];
  int                     pattern_len = 0;
  logic [PATTERN_MAX-1:0] progress_bits = '0;
  logic [COUNT_W-1:0]     occurrence_total = '0;
  logic                   dropped_word_seen = 1'b0;

  // Reports owed by the block, oldest first.
  result_t pending_reports [$];
  result_t oldest_report;

  subarray_occurrence_counter_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted transfer to the behavioral copy. A text word shifts
  // the progress bits: position p is set when position p-1 was set and the
  // word equals pattern word p. An occurrence ends when the top position of
  // the stored pattern is set.
  task automatic track_occurrences(input item_t it);
    logic [PATTERN_MAX-1:0] shifted;
    logic                   found;
    result_t                report;
    shifted = '0;
    found = 1'b0;
    case (it.command)
      CMD_CLEAR: begin
        pattern_len = 0;
        dropped_word_seen = 1'b0;
        progress_bits = '0;
        occurrence_total = '0;
      end
      CMD_APPEND: begin
        if (pattern_len < PATTERN_MAX) begin
          pattern_words[pattern_len] = it.value;
          progress_bits[pattern_len] = 1'b0;
          pattern_len++;
        end else begin
          dropped_word_seen = 1'b1;
        end
      end
      CMD_TEXT: begin
        for (int p = 0; p < pattern_len; p++) begin
          shifted[p] = ((p == 0) ? 1'b1 : progress_bits[p-1]) &&
                       (pattern_words[p] == it.value);
        end
        progress_bits = shifted;
        found = (pattern_len > 0) && progress_bits[pattern_len-1];
        if (found && occurrence_total != COUNT_MAX) begin
          occurrence_total++;
        end
        report.match_count = occurrence_total;
        report.match_here = found;
        report.final_res = it.last;
        report.pattern_overflow = dropped_word_seen;
        pending_reports.push_back(report);
        // The text is closed: the count and progress restart, the pattern stays.
        if (it.last) begin
          progress_bits = '0;
          occurrence_total = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Presents one item and holds it until its transfer completes. A random
  // number of idle cycles comes first. The valid stays high between items
  // when no idle cycle is drawn.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] word,
                           input logic fin);
    item_t it;
    it.command = cmd;
    it.value = word;
    it.last = fin;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data <= it;
    @(posedge clk);
    while (item_stall !== 1'b0) begin
      @(posedge clk);
    end
    track_occurrences(it);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Mostly extreme words, so that text words repeat pattern words often.
  function automatic logic [31:0] pick_symbol();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Right after reset the pattern is empty: text words never match.
  task automatic test_empty_pattern();
    send_item(CMD_TEXT, 32'h0000_0000, 1'b0);
    send_item(CMD_TEXT, 32'hFFFF_FFFF, 1'b1);
  endtask

  // The most negative and most positive words as pattern and text.
  task automatic test_extreme_words();
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_APPEND, 32'h8000_0000, 1'b0);
    send_item(CMD_APPEND, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_TEXT, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_TEXT, 32'h8000_0000, 1'b0);
    send_item(CMD_TEXT, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_TEXT, 32'h8000_0000, 1'b0);
    send_item(CMD_TEXT, 32'h7FFF_FFFF, 1'b1);
  endtask

  // Occurrences that share words must each be counted.
  task automatic test_overlap();
    send_item(CMD_CLEAR, 32'h0000_0000, 1'b0);
    send_item(CMD_APPEND, 32'd5, 1'b0);
    send_item(CMD_APPEND, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b1);
  endtask

  // Growing the pattern in the middle of a text keeps count and progress.
  task automatic test_append_mid_text();
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_APPEND, 32'd9, 1'b0);
    send_item(CMD_TEXT, 32'd9, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd5, 1'b0);
    send_item(CMD_TEXT, 32'd9, 1'b1);
  endtask

  // Code 3 must change nothing and give no report.
  task automatic test_reserved_command();
    send_item(CMD_RESERVED, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_TEXT, 32'd5, 1'b1);
  endtask

  // Fills the store, matches the whole pattern once, then drops words.
  task automatic test_pattern_capacity();
    logic [31:0] words [PATTERN_MAX];
    int i;
    send_item(CMD_CLEAR, $urandom, 1'b0);
    for (i = 0; i < PATTERN_MAX; i++) begin
      words[i] = $urandom;
      send_item(CMD_APPEND, words[i], 1'($urandom_range(0, 1)));
    end
    send_item(CMD_TEXT, words[0], 1'b0);
    for (i = 0; i < PATTERN_MAX; i++) begin
      send_item(CMD_TEXT, words[i], 1'b0);
    end
    send_item(CMD_APPEND, $urandom, 1'b0);
    send_item(CMD_APPEND, $urandom, 1'b1);
    send_item(CMD_TEXT, words[PATTERN_MAX-1], 1'b1);
    // A clear must drop the overflow flag again.
    send_item(CMD_CLEAR, $urandom, 1'b1);
    send_item(CMD_TEXT, words[0], 1'b1);
  endtask

  // Random texts against short random patterns over a small set of words.
  // A few transfers break the sequence: appends inside a text, clears in
  // the middle, reserved codes and stray words.
  task automatic test_random_texts(input int quota);
    logic [31:0] symbols [2];
    logic [31:0] word;
    int sent;
    int plen;
    int tlen;
    int roll;
    sent = 0;
    while (sent < quota) begin
      symbols[0] = pick_symbol();
      symbols[1] = pick_symbol();
      // Now and then the old pattern is kept and simply grows.
      if ($urandom_range(0, 9) != 0) begin
        send_item(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end
      plen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      for (int k = 0; k < plen; k++) begin
        send_item(CMD_APPEND, symbols[1'($urandom_range(0, 1))],
                  1'($urandom_range(0, 1)));
        sent++;
      end
      tlen = $urandom_range(1, 24);
      for (int k = 0; k < tlen; k++) begin
        roll = $urandom_range(0, 99);
        word = ($urandom_range(0, 99) < 85) ? symbols[1'($urandom_range(0, 1))]
                                            : $urandom;
        if (roll < 3) begin
          send_item(CMD_APPEND, word, 1'($urandom_range(0, 1)));
          sent++;
        end else if (roll < 5) begin
          send_item(CMD_RESERVED, $urandom, 1'($urandom_range(0, 1)));
        end else if (roll < 6) begin
          send_item(CMD_CLEAR, word, 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          send_item(CMD_TEXT, word, (k == tlen - 1) || ($urandom_range(0, 19) == 0));
          sent++;
        end
      end
    end
  endtask

  // The receiver stalls at random, drawn anew each cycle.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every result transfer is matched against the oldest owed report.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_data);
        error_count++;
      end else begin
        oldest_report = pending_reports.pop_front();
        report_field("match_count", 32'(oldest_report.match_count),
                     32'(res_data.match_count));
        report_field("match_here", 32'(oldest_report.match_here),
                     32'(res_data.match_here));
        report_field("final_res", 32'(oldest_report.final_res),
                     32'(res_data.final_res));
        report_field("pattern_overflow", 32'(oldest_report.pattern_overflow),
                     32'(res_data.pattern_overflow));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_idling(19, 58);
    test_empty_pattern();
    test_extreme_words();
    test_overlap();
    test_append_mid_text();
    test_reserved_command();
    test_pattern_capacity();
    test_random_texts(210);

    set_idling(58, 19);
    test_random_texts(210);

    set_idling(0, 0);
    test_random_texts(210);

    // Drain: every owed report must arrive, then a quiet tail catches extras.
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
